// ----- hw/rtl/cgn_pkg.sv -----
// ----------------------------------------------------------------------------
// cgn_pkg: shared definitions of the combined gradient noise unit
// Widths, register indexes, command codes, pipeline control types and the
// rounding helper used by several stages of the noise datapath.
// ----------------------------------------------------------------------------
package cgn_pkg;

   localparam int NUM_LAYERS        = 4;
   localparam int MAX_CELLS         = 63;
   localparam int CORNERS_PER_LAYER = 4096;
   localparam int STORE_DEPTH       = NUM_LAYERS * CORNERS_PER_LAYER;
   localparam int STORE_AW          = $clog2(STORE_DEPTH);

   localparam int LAYER_W   = 2;
   localparam int CORNER_W  = 12;
   localparam int GRAD_W    = 16;
   localparam int ENTRY_W   = 2 * GRAD_W;
   localparam int COORD_W   = 18;
   localparam int NOISE_W   = 20;
   localparam int COUNT_W   = 3;
   localparam int SETUP_W   = 48;
   localparam int SCALE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   localparam int CELL_W = $clog2(MAX_CELLS + 1);
   localparam int ROW_W  = $clog2(MAX_CELLS + 2);
   localparam int POS_W  = COORD_W + ROW_W;
   localparam int FRAC_W = 18;
   localparam int ONE_Q16 = 65536;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP3      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE       = 3'd5;

   localparam logic [COUNT_W-1:0] RST_LAYER_COUNT = 3'd1;
   localparam logic [SETUP_W-1:0] RST_SETUP       = 48'd257;
   localparam logic [SCALE_W-1:0] RST_SCALE       = 16'd23757;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam int NOISE_MAX = 524287;
   localparam int NOISE_MIN = -524288;

   typedef struct packed {
      logic                      command;
      logic [LAYER_W-1:0]        layer_index;
      logic [CORNER_W-1:0]       corner_index;
      logic signed [GRAD_W-1:0]  gradient_x;
      logic signed [GRAD_W-1:0]  gradient_y;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } req_item_type;

   // Control word that travels with every operation down the pipeline.
   typedef struct packed {
      logic               valid;
      logic               is_write;
      logic               first;
      logic               last;
      logic               has_layer;
      logic               live;
      logic [LAYER_W-1:0] layer;
   } op_ctrl_type;

   typedef struct packed {
      logic                          re;
      logic                          we;
      logic [STORE_AW-1:0]           waddr;
      logic [ENTRY_W-1:0]            wdata;
      logic [3:0][STORE_AW-1:0]      raddr;
   } mem_req_type;

   // Round half up then floor, i.e. (v + 2^(sh-1)) >>> sh.
   function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                    input int unsigned sh);
      logic signed [47:0] half;
      half = 48'sd1 <<< (sh - 1);
      return (v + half) >>> sh;
   endfunction

   function automatic logic [CELL_W-1:0] sat_cells(input logic [7:0] n);
      logic [CELL_W-1:0] r;
      if (32'(n) > MAX_CELLS) r = CELL_W'(MAX_CELLS);
      else r = CELL_W'(n);
      return r;
   endfunction

endpackage

// ----- hw/rtl/cgn_req_if.sv -----
// ----------------------------------------------------------------------------
// cgn_req_if: request channel of the gradient noise unit
// Valid/ready channel carrying one command beat: a gradient write or a point.
// ----------------------------------------------------------------------------
interface cgn_req_if import cgn_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [LAYER_W-1:0]        layer_index;
   logic [CORNER_W-1:0]       corner_index;
   logic signed [GRAD_W-1:0]  gradient_x;
   logic signed [GRAD_W-1:0]  gradient_y;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;

   modport source (output valid, command, layer_index, corner_index, gradient_x,
                   gradient_y, coord_x, coord_y, input ready);
   modport sink (input valid, command, layer_index, corner_index, gradient_x,
                 gradient_y, coord_x, coord_y, output ready);
endinterface

// ----- hw/rtl/cgn_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cgn_rsp_if: response channel of the gradient noise unit
// Valid/ready channel carrying one result beat per request beat.
// ----------------------------------------------------------------------------
interface cgn_rsp_if import cgn_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;
   logic                      is_write_ack;

   modport source (output valid, noise_value, is_write_ack, input ready);
   modport sink (input valid, noise_value, is_write_ack, output ready);
endinterface

// ----- hw/rtl/combined_gradient_noise_2d_unit.sv -----
// ----------------------------------------------------------------------------
// combined_gradient_noise_2d_unit: layered 2D gradient noise evaluator
// Sums up to four weighted gradient noise layers at a point, each layer with
// its own grid and gradient table, and loads gradient table entries.
//
//   Channel   Direction  Beat contents
//   req_bus   in         command, layer, corner, gradient pair, point
//   rsp_bus   out        saturated Q8.12 noise sum, write acknowledge flag
//   csr_*     in         register index and data, written on csr_we
//
// The sequencer issues one operation for a write beat and one per summed
// layer (at least one) for an evaluation beat, since each layer needs four
// corner reads from the two gradient RAM copies. Each operation passes the
// sequencer, stages B to J, the interpolator output, weighting and response
// registers in order; a point's response follows its last layer.
// Reset clears control state only; gradient entries are undefined until
// written and there is no clearing pass. A stalled response stalls the
// whole pipeline, including the gradient RAM read registers.
// ----------------------------------------------------------------------------
module combined_gradient_noise_2d_unit import cgn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   cgn_req_if.sink              req_bus,
   cgn_rsp_if.source            rsp_bus
);

   // Configuration registers. They must only be written while the unit is idle; the block does not enforce it.
   logic [COUNT_W-1:0] layer_count_ff;
   logic [SETUP_W-1:0] setup_ff [NUM_LAYERS];
   logic [SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= RST_LAYER_COUNT;
         for (int i = 0; i < NUM_LAYERS; i++) setup_ff[i] <= RST_SETUP;
         scale_ff <= RST_SCALE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SETUP0:      setup_ff[0] <= csr_wdata[SETUP_W-1:0];
            CSR_SETUP1:      setup_ff[1] <= csr_wdata[SETUP_W-1:0];
            CSR_SETUP2:      setup_ff[2] <= csr_wdata[SETUP_W-1:0];
            CSR_SETUP3:      setup_ff[3] <= csr_wdata[SETUP_W-1:0];
            CSR_SCALE:       scale_ff <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves as one whenever the response register can take a beat.
   logic         rsp_valid_ff;
   logic         advance;
   logic         can_take;
   req_item_type item;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance && can_take;

   always_comb begin
      item.command      = req_bus.command;
      item.layer_index  = req_bus.layer_index;
      item.corner_index = req_bus.corner_index;
      item.gradient_x   = req_bus.gradient_x;
      item.gradient_y   = req_bus.gradient_y;
      item.coord_x      = req_bus.coord_x;
      item.coord_y      = req_bus.coord_y;
   end

   mem_req_type              mem_req;
   op_ctrl_type              ctrl_c;
   logic signed [FRAC_W-1:0] fx_c, fy_c;

   cgn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .accept      (req_bus.valid),
      .item        (item),
      .layer_count (layer_count_ff),
      .setup       (setup_ff),
      .can_take    (can_take),
      .mem_req     (mem_req),
      .ctrl_c      (ctrl_c),
      .fx_c        (fx_c),
      .fy_c        (fy_c)
   );

   // Two copies of the gradient store, each with two read ports, read the
   // four corners of a cell together. Writes go to both copies.
   logic [3:0][ENTRY_W-1:0] grad;

   cgn_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_ram_top (
      .clock  (clock),
      .we     (mem_req.we),
      .waddr  (mem_req.waddr),
      .wdata  (mem_req.wdata),
      .re     (mem_req.re),
      .raddr0 (mem_req.raddr[0]),
      .raddr1 (mem_req.raddr[1]),
      .rdata0 (grad[0]),
      .rdata1 (grad[1])
   );

   cgn_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_ram_bot (
      .clock  (clock),
      .we     (mem_req.we),
      .waddr  (mem_req.waddr),
      .wdata  (mem_req.wdata),
      .re     (mem_req.re),
      .raddr0 (mem_req.raddr[2]),
      .raddr1 (mem_req.raddr[3]),
      .rdata0 (grad[2]),
      .rdata1 (grad[3])
   );

   op_ctrl_type        ctrl_k;
   logic signed [40:0] scaled_k;

   cgn_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctrl_in    (ctrl_c),
      .fx_in      (fx_c),
      .fy_in      (fy_c),
      .grad       (grad),
      .scale      (scale_ff),
      .ctrl_out   (ctrl_k),
      .scaled_out (scaled_k)
   );

   // Weighting: round the scaled value to Q.16 and multiply by the weight.
   logic signed [27:0] vsc_k;
   logic signed [43:0] wprod_k;
   logic [SETUP_W-1:0] setup_k;

   always_comb begin
      setup_k = setup_ff[ctrl_k.layer];
      vsc_k   = 28'(rnd_shift(48'(scaled_k), 14));
      wprod_k = vsc_k * $signed(setup_k[31:16]);
   end

   op_ctrl_type        ctrl_m_ff;
   logic signed [43:0] wprod_m_ff;

   always_ff @(posedge clock) begin
      if (reset) ctrl_m_ff <= '0;
      else if (advance) ctrl_m_ff <= ctrl_k;
      if (advance) wprod_m_ff <= wprod_k;
   end

   // Accumulate the layers of one point; the first layer restarts the sum.
   logic signed [31:0] acc_ff;
   logic signed [31:0] contrib_m, acc_in;
   logic [SETUP_W-1:0] setup_m;
   logic signed [NOISE_W-1:0] sat_m;
   logic signed [NOISE_W-1:0] noise_ff;
   logic                      ack_ff;

   always_comb begin
      setup_m = setup_ff[ctrl_m_ff.layer];
      if (ctrl_m_ff.has_layer) begin
         contrib_m = 32'(rnd_shift(48'(wprod_m_ff), 16)) + 32'($signed(setup_m[47:32]));
      end else begin
         contrib_m = 32'sd0;
      end
      acc_in = (ctrl_m_ff.first ? 32'sd0 : acc_ff) + contrib_m;
      if (acc_in > 32'(NOISE_MAX)) sat_m = NOISE_W'(NOISE_MAX);
      else if (acc_in < 32'(NOISE_MIN)) sat_m = NOISE_W'(NOISE_MIN);
      else sat_m = acc_in[NOISE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctrl_m_ff.valid && ctrl_m_ff.last;
      end
      if (advance && ctrl_m_ff.valid && !ctrl_m_ff.is_write) begin
         acc_ff <= acc_in;
      end
      if (advance && ctrl_m_ff.valid && ctrl_m_ff.last) begin
         noise_ff <= ctrl_m_ff.is_write ? '0 : sat_m;
         ack_ff   <= ctrl_m_ff.is_write;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.noise_value  = noise_ff;
   assign rsp_bus.is_write_ack = ack_ff;

endmodule

// ----- hw/rtl/cgn_ram.sv -----
// ----------------------------------------------------------------------------
// cgn_ram: generic synchronous RAM
// One write port and two read ports, read data registered, held when idle.
// ----------------------------------------------------------------------------
module cgn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr0,
   input  logic [AW-1:0]    raddr1,
   output logic [WIDTH-1:0] rdata0,
   output logic [WIDTH-1:0] rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata0_ff;
   logic [WIDTH-1:0] rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata0_ff <= mem_ff[raddr0];
         rdata1_ff <= mem_ff[raddr1];
      end
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

// ----- hw/rtl/cgn_front.sv -----
// ----------------------------------------------------------------------------
// cgn_front: layer sequencer and corner address generation
// Issues one operation per layer for a point, or one for a write, places the
// point on the layer grid and forms the four corner addresses or the gradient write.
// ----------------------------------------------------------------------------
module cgn_front import cgn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      accept,
   input  req_item_type              item,
   input  logic [COUNT_W-1:0]        layer_count,
   input  logic [SETUP_W-1:0]        setup [NUM_LAYERS],
   output logic                      can_take,
   output mem_req_type               mem_req,
   output op_ctrl_type               ctrl_c,
   output logic signed [FRAC_W-1:0]  fx_c,
   output logic signed [FRAC_W-1:0]  fy_c
);

   // Stage A: sequencer
   logic               a_valid_ff, a_valid_in;
   logic [LAYER_W-1:0] a_layer_ff, a_layer_in;
   logic [COUNT_W-1:0] a_n_ff;
   req_item_type       a_item_ff;
   logic [COUNT_W-1:0] n_eff;
   logic               a_last;
   logic [SETUP_W-1:0] setup_a;
   logic [CELL_W-1:0]  nx_a, ny_a;
   logic signed [POS_W-1:0] px_a, py_a;
   op_ctrl_type        ctrl_a;
   logic               wr_ok_a;

   always_comb begin
      if (32'(layer_count) > NUM_LAYERS) n_eff = COUNT_W'(NUM_LAYERS);
      else n_eff = layer_count;
      a_last = (a_item_ff.command == CMD_WRITE) || (32'(a_layer_ff) + 1 >= 32'(a_n_ff));
      can_take = !a_valid_ff || a_last;
      a_valid_in = a_valid_ff;
      a_layer_in = a_layer_ff;
      if (advance) begin
         if (a_valid_ff && !a_last) begin
            a_layer_in = a_layer_ff + 1'b1;
         end else if (accept) begin
            a_valid_in = 1'b1;
            a_layer_in = '0;
         end else begin
            a_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_layer_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_layer_ff <= a_layer_in;
      end
      if (advance && accept && can_take) begin
         a_item_ff <= item;
         a_n_ff    <= n_eff;
      end
   end

   always_comb begin
      setup_a = setup[a_layer_ff];
      nx_a = sat_cells(setup_a[7:0]);
      ny_a = sat_cells(setup_a[15:8]);
      px_a = a_item_ff.coord_x * $signed({1'b0, nx_a});
      py_a = a_item_ff.coord_y * $signed({1'b0, ny_a});
      ctrl_a.valid     = a_valid_ff;
      ctrl_a.is_write  = (a_item_ff.command == CMD_WRITE);
      ctrl_a.first     = (a_layer_ff == '0);
      ctrl_a.last      = a_last;
      ctrl_a.has_layer = (a_n_ff != '0);
      ctrl_a.live      = 1'b0;
      ctrl_a.layer     = a_layer_ff;
      wr_ok_a = (32'(a_item_ff.layer_index) < NUM_LAYERS)
             && (32'(a_item_ff.corner_index) < CORNERS_PER_LAYER);
   end

   // Stage B: cell and fraction
   op_ctrl_type             ctrl_b_ff;
   logic signed [POS_W-1:0] px_b_ff, py_b_ff;
   logic [CELL_W-1:0]       nx_b_ff, ny_b_ff;
   logic                    wr_ok_b_ff;
   logic [STORE_AW-1:0]     waddr_b_ff;
   logic [ENTRY_W-1:0]      wdata_b_ff;
   logic signed [POS_W-1:0] cx_b, cy_b;
   logic signed [POS_W-1:0] fx_full, fy_full;
   logic                    okx_b, oky_b, fit_b;
   op_ctrl_type             ctrl_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_b_ff <= '0;
      end else if (advance) begin
         ctrl_b_ff <= ctrl_a;
      end
      if (advance) begin
         px_b_ff    <= px_a;
         py_b_ff    <= py_a;
         nx_b_ff    <= nx_a;
         ny_b_ff    <= ny_a;
         wr_ok_b_ff <= wr_ok_a;
         waddr_b_ff <= {a_item_ff.layer_index, a_item_ff.corner_index};
         wdata_b_ff <= {a_item_ff.gradient_y, a_item_ff.gradient_x};
      end
   end

   always_comb begin
      // Truncation toward zero, as an integer cast does.
      cx_b = (px_b_ff + (px_b_ff[POS_W-1] ? POS_W'(ONE_Q16 - 1) : POS_W'(0))) >>> 16;
      cy_b = (py_b_ff + (py_b_ff[POS_W-1] ? POS_W'(ONE_Q16 - 1) : POS_W'(0))) >>> 16;
      fx_full = px_b_ff - (cx_b <<< 16);
      fy_full = py_b_ff - (cy_b <<< 16);
      okx_b = !cx_b[POS_W-1] && (cx_b[POS_W-2:0] < (POS_W-1)'(nx_b_ff));
      oky_b = !cy_b[POS_W-1] && (cy_b[POS_W-2:0] < (POS_W-1)'(ny_b_ff));
      fit_b = (32'(ny_b_ff) + 1) * (32'(nx_b_ff) + 1) <= CORNERS_PER_LAYER;
      ctrl_b = ctrl_b_ff;
      ctrl_b.live = ctrl_b_ff.has_layer && okx_b && oky_b && fit_b;
   end

   // Stage C: corner addresses and memory access
   logic [CELL_W-1:0]   cx_c_ff, cy_c_ff;
   logic [ROW_W-1:0]    row_c_ff;
   logic                wr_ok_c_ff;
   logic [STORE_AW-1:0] waddr_c_ff;
   logic [ENTRY_W-1:0]  wdata_c_ff;
   logic [CORNER_W-1:0] base_c, base_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_c <= '0;
      end else if (advance) begin
         ctrl_c <= ctrl_b;
      end
      if (advance) begin
         fx_c       <= fx_full[FRAC_W-1:0];
         fy_c       <= fy_full[FRAC_W-1:0];
         cx_c_ff    <= cx_b[CELL_W-1:0];
         cy_c_ff    <= cy_b[CELL_W-1:0];
         row_c_ff   <= ROW_W'(32'(nx_b_ff) + 1);
         wr_ok_c_ff <= wr_ok_b_ff;
         waddr_c_ff <= waddr_b_ff;
         wdata_c_ff <= wdata_b_ff;
      end
   end

   always_comb begin
      base_c = CORNER_W'(32'(cy_c_ff) * 32'(row_c_ff) + 32'(cx_c_ff));
      base_r = base_c + CORNER_W'(row_c_ff);
      mem_req.re       = advance;
      mem_req.we       = advance && ctrl_c.valid && ctrl_c.is_write && wr_ok_c_ff;
      mem_req.waddr    = waddr_c_ff;
      mem_req.wdata    = wdata_c_ff;
      mem_req.raddr[0] = {ctrl_c.layer, base_c};
      mem_req.raddr[1] = {ctrl_c.layer, base_c + 1'b1};
      mem_req.raddr[2] = {ctrl_c.layer, base_r};
      mem_req.raddr[3] = {ctrl_c.layer, base_r + 1'b1};
   end

endmodule

// ----- hw/rtl/cgn_interp.sv -----
// ----------------------------------------------------------------------------
// cgn_interp: corner dot products, smoothstep blend and output scaling
// Pipelined datapath from the four corner gradients to the scaled layer value.
// ----------------------------------------------------------------------------
module cgn_interp import cgn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  op_ctrl_type               ctrl_in,
   input  logic signed [FRAC_W-1:0]  fx_in,
   input  logic signed [FRAC_W-1:0]  fy_in,
   input  logic [3:0][ENTRY_W-1:0]   grad,
   input  logic [SCALE_W-1:0]        scale,
   output op_ctrl_type               ctrl_out,
   output logic signed [40:0]        scaled_out
);

   // Stage D: products, read data comes straight from the RAMs
   op_ctrl_type              ctrl_d_ff;
   logic signed [FRAC_W-1:0] fx_d_ff, fy_d_ff;
   logic signed [FRAC_W-1:0] dx0, dx1, dy0, dy1;
   logic [16:0]              wx_d, wy_d;
   logic signed [33:0]       pgx [4];
   logic signed [33:0]       pgy [4];
   logic [33:0]              sqx_d, sqy_d;

   always_ff @(posedge clock) begin
      if (reset) ctrl_d_ff <= '0;
      else if (advance) ctrl_d_ff <= ctrl_in;
      if (advance) begin
         fx_d_ff <= fx_in;
         fy_d_ff <= fy_in;
      end
   end

   always_comb begin
      dx0 = fx_d_ff;
      dy0 = fy_d_ff;
      dx1 = FRAC_W'($signed({fx_d_ff[FRAC_W-1], fx_d_ff}) - 19'sd65536);
      dy1 = FRAC_W'($signed({fy_d_ff[FRAC_W-1], fy_d_ff}) - 19'sd65536);
      if (fx_d_ff[FRAC_W-1]) wx_d = '0;
      else if (fx_d_ff > FRAC_W'(ONE_Q16)) wx_d = 17'(ONE_Q16);
      else wx_d = fx_d_ff[16:0];
      if (fy_d_ff[FRAC_W-1]) wy_d = '0;
      else if (fy_d_ff > FRAC_W'(ONE_Q16)) wy_d = 17'(ONE_Q16);
      else wy_d = fy_d_ff[16:0];
      sqx_d = wx_d * wx_d;
      sqy_d = wy_d * wy_d;
      // Corner order: 00, 10, 01, 11.
      pgx[0] = $signed(grad[0][15:0]) * dx0;
      pgy[0] = $signed(grad[0][31:16]) * dy0;
      pgx[1] = $signed(grad[1][15:0]) * dx1;
      pgy[1] = $signed(grad[1][31:16]) * dy0;
      pgx[2] = $signed(grad[2][15:0]) * dx0;
      pgy[2] = $signed(grad[2][31:16]) * dy1;
      pgx[3] = $signed(grad[3][15:0]) * dx1;
      pgy[3] = $signed(grad[3][31:16]) * dy1;
   end

   // Stage E: dot products and smoothstep square
   op_ctrl_type        ctrl_e_ff;
   logic signed [33:0] pgx_e_ff [4];
   logic signed [33:0] pgy_e_ff [4];
   logic [33:0]        sqx_e_ff, sqy_e_ff;
   logic [16:0]        wx_e_ff, wy_e_ff;
   logic signed [20:0] dot_e [4];
   logic [16:0]        w2x_e, w2y_e;
   logic [17:0]        kx_e, ky_e;

   always_ff @(posedge clock) begin
      if (reset) ctrl_e_ff <= '0;
      else if (advance) ctrl_e_ff <= ctrl_d_ff;
      if (advance) begin
         pgx_e_ff <= pgx;
         pgy_e_ff <= pgy;
         sqx_e_ff <= sqx_d;
         sqy_e_ff <= sqy_d;
         wx_e_ff  <= wx_d;
         wy_e_ff  <= wy_d;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dot_e[i] = ctrl_e_ff.live
                  ? 21'(rnd_shift(48'(pgx_e_ff[i]) + 48'(pgy_e_ff[i]), 14)) : 21'sd0;
      end
      w2x_e = 17'(rnd_shift($signed(48'(sqx_e_ff)), 16));
      w2y_e = 17'(rnd_shift($signed(48'(sqy_e_ff)), 16));
      kx_e = 18'(19'd196608 - {wx_e_ff, 1'b0});
      ky_e = 18'(19'd196608 - {wy_e_ff, 1'b0});
   end

   // Stage F: smoothstep product and corner differences
   op_ctrl_type        ctrl_f_ff;
   logic signed [20:0] d00_f_ff, d10_f_ff, d01_f_ff, d11_f_ff;
   logic [16:0]        w2x_f_ff, w2y_f_ff;
   logic [17:0]        kx_f_ff, ky_f_ff;
   logic [34:0]        spx_f, spy_f;
   logic signed [21:0] dif0_f, dif1_f;

   always_ff @(posedge clock) begin
      if (reset) ctrl_f_ff <= '0;
      else if (advance) ctrl_f_ff <= ctrl_e_ff;
      if (advance) begin
         d00_f_ff <= dot_e[0];
         d10_f_ff <= dot_e[1];
         d01_f_ff <= dot_e[2];
         d11_f_ff <= dot_e[3];
         w2x_f_ff <= w2x_e;
         w2y_f_ff <= w2y_e;
         kx_f_ff  <= kx_e;
         ky_f_ff  <= ky_e;
      end
   end

   always_comb begin
      spx_f = w2x_f_ff * kx_f_ff;
      spy_f = w2y_f_ff * ky_f_ff;
      dif0_f = 22'(d10_f_ff) - 22'(d00_f_ff);
      dif1_f = 22'(d11_f_ff) - 22'(d01_f_ff);
   end

   // Stage G: blend products along x
   op_ctrl_type        ctrl_g_ff;
   logic [34:0]        spx_g_ff, spy_g_ff;
   logic signed [21:0] dif0_g_ff, dif1_g_ff;
   logic signed [20:0] d00_g_ff, d01_g_ff;
   logic [16:0]        sx_g, sy_g;
   logic signed [39:0] m0_g, m1_g;

   always_ff @(posedge clock) begin
      if (reset) ctrl_g_ff <= '0;
      else if (advance) ctrl_g_ff <= ctrl_f_ff;
      if (advance) begin
         spx_g_ff  <= spx_f;
         spy_g_ff  <= spy_f;
         dif0_g_ff <= dif0_f;
         dif1_g_ff <= dif1_f;
         d00_g_ff  <= d00_f_ff;
         d01_g_ff  <= d01_f_ff;
      end
   end

   always_comb begin
      sx_g = 17'(rnd_shift($signed(48'(spx_g_ff)), 16));
      sy_g = 17'(rnd_shift($signed(48'(spy_g_ff)), 16));
      m0_g = dif0_g_ff * $signed({1'b0, sx_g});
      m1_g = dif1_g_ff * $signed({1'b0, sx_g});
   end

   // Stage H: x blends
   op_ctrl_type        ctrl_h_ff;
   logic signed [39:0] m0_h_ff, m1_h_ff;
   logic signed [20:0] d00_h_ff, d01_h_ff;
   logic [16:0]        sy_h_ff;
   logic signed [22:0] s0_h, s1_h;

   always_ff @(posedge clock) begin
      if (reset) ctrl_h_ff <= '0;
      else if (advance) ctrl_h_ff <= ctrl_g_ff;
      if (advance) begin
         m0_h_ff  <= m0_g;
         m1_h_ff  <= m1_g;
         d00_h_ff <= d00_g_ff;
         d01_h_ff <= d01_g_ff;
         sy_h_ff  <= sy_g;
      end
   end

   always_comb begin
      s0_h = 23'(d00_h_ff) + 23'(rnd_shift(48'(m0_h_ff), 16));
      s1_h = 23'(d01_h_ff) + 23'(rnd_shift(48'(m1_h_ff), 16));
   end

   // Stage I: blend product along y
   op_ctrl_type        ctrl_i_ff;
   logic signed [22:0] s0_i_ff, s1_i_ff;
   logic [16:0]        sy_i_ff;
   logic signed [41:0] my_i;

   always_ff @(posedge clock) begin
      if (reset) ctrl_i_ff <= '0;
      else if (advance) ctrl_i_ff <= ctrl_h_ff;
      if (advance) begin
         s0_i_ff <= s0_h;
         s1_i_ff <= s1_h;
         sy_i_ff <= sy_h_ff;
      end
   end

   always_comb begin
      my_i = (24'(s1_i_ff) - 24'(s0_i_ff)) * $signed({1'b0, sy_i_ff});
   end

   // Stage J: layer value and output scaling
   op_ctrl_type        ctrl_j_ff;
   logic signed [41:0] my_j_ff;
   logic signed [22:0] s0_j_ff;
   logic signed [23:0] v_j;
   logic signed [40:0] vp_j;

   always_ff @(posedge clock) begin
      if (reset) ctrl_j_ff <= '0;
      else if (advance) ctrl_j_ff <= ctrl_i_ff;
      if (advance) begin
         my_j_ff <= my_i;
         s0_j_ff <= s0_i_ff;
      end
   end

   always_comb begin
      v_j  = 24'(s0_j_ff) + 24'(rnd_shift(48'(my_j_ff), 16));
      vp_j = v_j * $signed({1'b0, scale});
   end

   always_ff @(posedge clock) begin
      if (reset) ctrl_out <= '0;
      else if (advance) ctrl_out <= ctrl_j_ff;
      if (advance) scaled_out <= vp_j;
   end

endmodule
